// ----- sv/triangle_adjacency_builder_macros.svh -----
// assertion macros for the triangle adjacency builder
`ifndef TRIANGLE_ADJACENCY_BUILDER_MACROS_SVH
`define TRIANGLE_ADJACENCY_BUILDER_MACROS_SVH
`ifndef ASSERT_OFF
// clocked property, skipped while reset is low
`define TAB_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("tab assertion failed");
// clocked property, checked during reset too
`define TAB_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("tab assertion failed");
`else
`define TAB_ASSERT(lbl, clk, rst_n, prop)
`define TAB_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// ----- sv/tab_pkg.sv -----
// shared types and constants of the triangle adjacency builder
package tab_pkg;

    localparam int VERT_W = 16;
    localparam logic [63:0] HASH_MULT = 64'h9E37_79B9_7F4A_7C15;

    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_QUERY  = 2'd1;
    localparam logic [1:0] ACT_CLEAR  = 2'd2;

    localparam logic [1:0] SEL_FIRST  = 2'd0;
    localparam logic [1:0] SEL_SECOND = 2'd1;
    localparam logic [1:0] SEL_THIRD  = 2'd2;

    typedef struct packed {
        logic       load_in;
        logic       hash_start;
        logic       probe_init;
        logic       probe_read;
        logic       probe_next;
        logic       fresh_inc;
        logic       put;
        logic       adj_cap;
        logic       clear_init;
        logic       clear_step;
        logic       count_clear;
        logic       out_load;
        logic       drop;
        logic [1:0] sel;
    } cmd_t;

    typedef struct packed {
        logic hash_done;
        logic hit;
        logic empty;
        logic last;
        logic dup;
        logic no_room;
        logic clear_last;
        logic out_free;
    } sts_t;

endpackage

// ----- sv/tab_ram.sv -----
// generic single write port ram with registered read
module tab_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/tab_hash.sv -----
// multiplicative hash of an edge key onto a table slot
module tab_hash #(
    parameter int KEY_W = 32,
    parameter int SLOTS = 4096
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic [KEY_W-1:0]         key,
    output logic                     done,
    output logic [$clog2(SLOTS)-1:0] slot
);

    localparam int SW = $clog2(SLOTS);
    localparam bit IS_POW2 = (SLOTS & (SLOTS - 1)) == 0;
    // floor(2^(32+SW) / SLOTS), fits in 33 bits
    localparam logic [63:0] RECIP_FULL = (64'd1 << (32 + SW)) / 64'(SLOTS);
    localparam logic [31:0] RECIP_LO   = RECIP_FULL[31:0];
    localparam bit          RECIP_HI   = RECIP_FULL[32];

    logic [63:0]   key_reg;
    logic [1:0]    st_reg;
    logic          run_reg;
    logic          mod_run_reg;
    logic          done_reg;
    logic [1:0]    mst_reg;
    logic [63:0]   prod_reg;
    logic [31:0]   acc_reg;
    logic [31:0]   x_reg;
    logic [63:0]   mprod_reg;
    logic [31:0]   q_reg;
    logic [SW:0]   r_reg;
    logic [SW-1:0] slot_reg;
    logic [31:0]   opa;
    logic [31:0]   opb;
    logic [31:0]   acc_fin;
    logic [64:0]   qsum;
    logic [48:0]   qd;
    logic [48:0]   r_full;

    // high word of key * mult mod 2^64 from three 32x32 partial products
    always_comb begin
        case (st_reg)
            2'd0: begin
                opa = key_reg[31:0];
                opb = tab_pkg::HASH_MULT[31:0];
            end
            2'd1: begin
                opa = key_reg[31:0];
                opb = tab_pkg::HASH_MULT[63:32];
            end
            default: begin
                opa = key_reg[63:32];
                opb = tab_pkg::HASH_MULT[31:0];
            end
        endcase
    end

    assign acc_fin = acc_reg + prod_reg[31:0];
    // quotient estimate is the true quotient or one less
    assign qsum    = 65'(mprod_reg) + (RECIP_HI ? {1'b0, x_reg, 32'd0} : 65'd0);
    assign qd      = 49'(q_reg) * 49'(SLOTS);
    assign r_full  = 49'(x_reg) - qd;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg     <= 1'b0;
            mod_run_reg <= 1'b0;
            done_reg    <= 1'b0;
            st_reg      <= 2'd0;
            mst_reg     <= 2'd0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                key_reg <= 64'(key);
                st_reg  <= 2'd0;
                run_reg <= 1'b1;
            end else if (run_reg) begin
                prod_reg <= opa * opb;
                st_reg   <= st_reg + 2'd1;
                case (st_reg)
                    2'd0: begin
                    end
                    2'd1: begin
                        acc_reg <= prod_reg[63:32];
                    end
                    2'd2: begin
                        acc_reg <= acc_fin;
                    end
                    default: begin
                        run_reg <= 1'b0;
                        if (IS_POW2) begin
                            slot_reg <= acc_fin[SW-1:0];
                            done_reg <= 1'b1;
                        end else begin
                            x_reg       <= acc_fin;
                            mst_reg     <= 2'd0;
                            mod_run_reg <= 1'b1;
                        end
                    end
                endcase
            end else if (mod_run_reg) begin
                // remainder by reciprocal multiply, then one correction step
                mst_reg <= mst_reg + 2'd1;
                case (mst_reg)
                    2'd0: mprod_reg <= x_reg * RECIP_LO;
                    2'd1: q_reg <= 32'(qsum >> (32 + SW));
                    2'd2: r_reg <= r_full[SW:0];
                    default: begin
                        slot_reg    <= (r_reg >= (SW+1)'(SLOTS))
                                       ? SW'(r_reg - (SW+1)'(SLOTS)) : SW'(r_reg);
                        done_reg    <= 1'b1;
                        mod_run_reg <= 1'b0;
                    end
                endcase
            end
        end
    end

    assign done = done_reg;
    assign slot = slot_reg;

endmodule

// ----- sv/tab_ctrl.sv -----
// sequencer for insert, query and clear; any other action goes straight to the result
`include "triangle_adjacency_builder_macros.svh"
module tab_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  logic [1:0]    s_action,
    input  tab_pkg::sts_t sts,
    output tab_pkg::cmd_t cmd
);

    typedef enum logic [2:0] {
        ST_CLEAR, ST_IDLE, ST_HSTART, ST_HWAIT, ST_RD, ST_CHK, ST_ROOM, ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        PH_COUNT, PH_PUT, PH_QUERY
    } phase_t;

    state_t     state_reg;
    phase_t     phase_reg;
    logic [1:0] sel_reg;
    logic       drop_reg;
    logic       clr_item_reg;
    logic       resolved;

    assign resolved = sts.hit || sts.empty || sts.last;
    assign s_ready  = (state_reg == ST_IDLE);

    always_comb begin
        cmd      = '0;
        cmd.sel  = sel_reg;
        cmd.drop = drop_reg;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clear_step  = 1'b1;
                cmd.count_clear = sts.clear_last;
            end
            ST_IDLE: begin
                cmd.load_in    = s_valid;
                cmd.clear_init = s_valid && (s_action == tab_pkg::ACT_CLEAR);
            end
            ST_HSTART: cmd.hash_start = 1'b1;
            ST_HWAIT:  cmd.probe_init = sts.hash_done;
            ST_RD:     cmd.probe_read = 1'b1;
            ST_CHK: begin
                if (!resolved) begin
                    cmd.probe_next = 1'b1;
                end else begin
                    case (phase_reg)
                        PH_COUNT: cmd.fresh_inc = !sts.hit && !sts.dup;
                        PH_PUT:   cmd.put = 1'b1;
                        default:  cmd.adj_cap = 1'b1;
                    endcase
                end
            end
            ST_DONE: cmd.out_load = sts.out_free;
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            phase_reg    <= PH_COUNT;
            sel_reg      <= tab_pkg::SEL_FIRST;
            drop_reg     <= 1'b0;
            clr_item_reg <= 1'b0;
        end else begin
            case (state_reg)
                ST_CLEAR: begin
                    if (sts.clear_last) begin
                        state_reg    <= clr_item_reg ? ST_DONE : ST_IDLE;
                        clr_item_reg <= 1'b0;
                    end
                end
                ST_IDLE: begin
                    if (s_valid) begin
                        drop_reg <= 1'b0;
                        sel_reg  <= tab_pkg::SEL_FIRST;
                        case (s_action)
                            tab_pkg::ACT_INSERT: begin
                                phase_reg <= PH_COUNT;
                                state_reg <= ST_HSTART;
                            end
                            tab_pkg::ACT_QUERY: begin
                                phase_reg <= PH_QUERY;
                                state_reg <= ST_HSTART;
                            end
                            tab_pkg::ACT_CLEAR: begin
                                clr_item_reg <= 1'b1;
                                state_reg    <= ST_CLEAR;
                            end
                            default: state_reg <= ST_DONE;
                        endcase
                    end
                end
                ST_HSTART: state_reg <= ST_HWAIT;
                ST_HWAIT: begin
                    if (sts.hash_done) begin
                        state_reg <= ST_RD;
                    end
                end
                ST_RD: state_reg <= ST_CHK;
                ST_CHK: begin
                    if (!resolved) begin
                        state_reg <= ST_RD;
                    end else if (sel_reg == tab_pkg::SEL_THIRD) begin
                        state_reg <= (phase_reg == PH_COUNT) ? ST_ROOM : ST_DONE;
                    end else begin
                        sel_reg   <= sel_reg + 2'd1;
                        state_reg <= ST_HSTART;
                    end
                end
                ST_ROOM: begin
                    if (sts.no_room) begin
                        drop_reg  <= 1'b1;
                        state_reg <= ST_DONE;
                    end else begin
                        phase_reg <= PH_PUT;
                        sel_reg   <= tab_pkg::SEL_FIRST;
                        state_reg <= ST_HSTART;
                    end
                end
                ST_DONE: begin
                    if (sts.out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    `TAB_ASSERT(a_accept_leaves_idle, aclk, aresetn, s_valid && s_ready |=> state_reg != ST_IDLE)
    `TAB_ASSERT(a_load_when_free, aclk, aresetn, cmd.out_load |-> sts.out_free)
    `TAB_ASSERT(a_put_after_room, aclk, aresetn, cmd.put |-> !drop_reg)

endmodule

// ----- sv/tab_dp.sv -----
// datapath: edge keys, probe pointer, table memory, counts and result register
`include "triangle_adjacency_builder_macros.svh"
module tab_dp #(
    parameter int EDGE_SLOTS = 4096,
    parameter int INDEX_BITS = 16
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic [1:0]    s_action,
    input  logic [15:0]   s_vertex_a,
    input  logic [15:0]   s_vertex_b,
    input  logic [15:0]   s_vertex_c,
    input  tab_pkg::cmd_t cmd,
    output tab_pkg::sts_t sts,
    output logic          m_valid,
    input  logic          m_ready,
    output logic          m_status,
    output logic [15:0]   m_out_first,
    output logic [15:0]   m_adj_across_ab,
    output logic [15:0]   m_out_second,
    output logic [15:0]   m_adj_across_bc,
    output logic [15:0]   m_out_third,
    output logic [15:0]   m_adj_across_ca
);

    localparam int SW = $clog2(EDGE_SLOTS);
    localparam int CW = $clog2(EDGE_SLOTS + 1);
    localparam int KW = INDEX_BITS + tab_pkg::VERT_W;
    localparam int VW = tab_pkg::VERT_W;
    localparam int EW = 1 + KW + VW;

    function automatic logic [KW-1:0] pack_key(input logic [VW-1:0] f, input logic [VW-1:0] t);
        return KW'((64'(f) << INDEX_BITS) | 64'(t));
    endfunction

    logic [1:0]    act_reg;
    logic [VW-1:0] va_reg, vb_reg, vc_reg;
    logic [SW-1:0] slot_reg;
    logic [SW-1:0] n_reg;
    logic [SW-1:0] clr_ptr_reg;
    logic [CW-1:0] count_reg;
    logic [1:0]    fresh_reg;
    logic [VW-1:0] adj0_reg, adj1_reg, adj2_reg;
    logic          m_valid_reg;
    logic          status_reg;
    logic [VW-1:0] first_reg, second_reg, third_reg;
    logic [VW-1:0] oab_reg, obc_reg, oca_reg;

    logic [KW-1:0] ik0, ik1, ik2;
    logic [KW-1:0] key;
    logic [VW-1:0] val;
    logic [VW-1:0] fallback;
    logic          dup;
    logic          hash_done;
    logic [SW-1:0] hash_slot;
    logic          ram_we;
    logic [SW-1:0] ram_waddr;
    logic [EW-1:0] ram_wdata;
    logic [EW-1:0] ram_rdata;
    logic          is_query;

    assign ik0 = pack_key(va_reg, vb_reg);
    assign ik1 = pack_key(vb_reg, vc_reg);
    assign ik2 = pack_key(vc_reg, va_reg);
    assign is_query = (act_reg == tab_pkg::ACT_QUERY);

    // insert edges (a,b)->c (b,c)->a (c,a)->b; query edges (b,a) (c,b) (a,c)
    always_comb begin
        case (cmd.sel)
            tab_pkg::SEL_FIRST: begin
                key      = is_query ? pack_key(vb_reg, va_reg) : ik0;
                val      = vc_reg;
                fallback = va_reg;
                dup      = 1'b0;
            end
            tab_pkg::SEL_SECOND: begin
                key      = is_query ? pack_key(vc_reg, vb_reg) : ik1;
                val      = va_reg;
                fallback = vb_reg;
                dup      = (ik1 == ik0);
            end
            default: begin
                key      = is_query ? pack_key(va_reg, vc_reg) : ik2;
                val      = vb_reg;
                fallback = vc_reg;
                dup      = (ik2 == ik0) || (ik2 == ik1);
            end
        endcase
    end

    tab_hash #(
        .KEY_W (KW),
        .SLOTS (EDGE_SLOTS)
    ) u_hash (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.hash_start),
        .key     (key),
        .done    (hash_done),
        .slot    (hash_slot)
    );

    // entry layout: valid, key, opposite vertex
    assign ram_we    = cmd.clear_step || (cmd.put && (sts.hit || sts.empty));
    assign ram_waddr = cmd.clear_step ? clr_ptr_reg : slot_reg;
    assign ram_wdata = cmd.clear_step ? '0 : {1'b1, key, val};

    tab_ram #(
        .WIDTH (EW),
        .DEPTH (EDGE_SLOTS)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.probe_read),
        .raddr (slot_reg),
        .rdata (ram_rdata)
    );

    assign sts.hash_done  = hash_done;
    assign sts.dup        = dup;
    assign sts.hit        = ram_rdata[EW-1] && (ram_rdata[EW-2:VW] == key);
    assign sts.empty      = !ram_rdata[EW-1];
    assign sts.last       = (n_reg == SW'(EDGE_SLOTS - 1));
    assign sts.no_room    = ((CW+1)'(count_reg) + (CW+1)'(fresh_reg)) > (CW+1)'(EDGE_SLOTS);
    assign sts.clear_last = (clr_ptr_reg == SW'(EDGE_SLOTS - 1));
    assign sts.out_free   = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_ptr_reg <= '0;
            count_reg   <= '0;
            fresh_reg   <= '0;
            m_valid_reg <= 1'b0;
            n_reg       <= '0;
        end else begin
            if (cmd.load_in) begin
                act_reg   <= s_action;
                va_reg    <= s_vertex_a;
                vb_reg    <= s_vertex_b;
                vc_reg    <= s_vertex_c;
                fresh_reg <= '0;
            end
            if (cmd.probe_init) begin
                slot_reg <= hash_slot;
                n_reg    <= '0;
            end else if (cmd.probe_next) begin
                slot_reg <= (slot_reg == SW'(EDGE_SLOTS - 1)) ? '0 : slot_reg + 1'b1;
                n_reg    <= n_reg + 1'b1;
            end
            if (cmd.fresh_inc) begin
                fresh_reg <= fresh_reg + 2'd1;
            end
            if (cmd.clear_init) begin
                clr_ptr_reg <= '0;
            end else if (cmd.clear_step) begin
                clr_ptr_reg <= sts.clear_last ? '0 : clr_ptr_reg + 1'b1;
            end
            if (cmd.count_clear) begin
                count_reg <= '0;
            end else if (cmd.put && sts.empty) begin
                count_reg <= count_reg + 1'b1;
            end
            if (cmd.adj_cap) begin
                case (cmd.sel)
                    tab_pkg::SEL_FIRST:  adj0_reg <= sts.hit ? ram_rdata[VW-1:0] : fallback;
                    tab_pkg::SEL_SECOND: adj1_reg <= sts.hit ? ram_rdata[VW-1:0] : fallback;
                    default:             adj2_reg <= sts.hit ? ram_rdata[VW-1:0] : fallback;
                endcase
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
                status_reg  <= cmd.drop;
                first_reg   <= is_query ? va_reg : '0;
                second_reg  <= is_query ? vb_reg : '0;
                third_reg   <= is_query ? vc_reg : '0;
                oab_reg     <= is_query ? adj0_reg : '0;
                obc_reg     <= is_query ? adj1_reg : '0;
                oca_reg     <= is_query ? adj2_reg : '0;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = status_reg;
    assign m_out_first     = first_reg;
    assign m_adj_across_ab = oab_reg;
    assign m_out_second    = second_reg;
    assign m_adj_across_bc = obc_reg;
    assign m_out_third     = third_reg;
    assign m_adj_across_ca = oca_reg;

    `TAB_ASSERT(a_count_bound, aclk, aresetn, count_reg <= CW'(EDGE_SLOTS))
    `TAB_ASSERT(a_put_after_read, aclk, aresetn, cmd.put |-> $past(cmd.probe_read))
    `TAB_ASSERT_ALWAYS(a_no_read_in_sweep, aclk, !(cmd.clear_step && cmd.probe_read))

endmodule

// ----- sv/triangle_adjacency_builder.sv -----
// top level of the triangle adjacency builder
// lookup: hash (plus modulo if EDGE_SLOTS is not a power of two), then a read and check per probe
// query: three lookups; insert: three to count new edges, then three more to write if there is room
// clear: sweeps the whole table memory, then the result transfer
// one item at a time: s_ready is high only while the sequencer is idle
// reset: synchronous active-low aresetn; afterwards the table is swept before any item is taken
module triangle_adjacency_builder #(
    parameter int EDGE_SLOTS = 4096,
    parameter int INDEX_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input triangle transfer
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_action,
    input  logic [15:0] s_vertex_a,
    input  logic [15:0] s_vertex_b,
    input  logic [15:0] s_vertex_c,
    // result transfer
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_status,
    output logic [15:0] m_out_first,
    output logic [15:0] m_adj_across_ab,
    output logic [15:0] m_out_second,
    output logic [15:0] m_adj_across_bc,
    output logic [15:0] m_out_third,
    output logic [15:0] m_adj_across_ca
);

    // command and status between sequencer and datapath
    tab_pkg::cmd_t cmd;
    tab_pkg::sts_t sts;

    // sequencer: probe loop, room check for all-or-nothing insert, clear sweep
    tab_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_action (s_action),
        .sts      (sts),
        .cmd      (cmd)
    );

    // datapath: hash unit, edge table, entry count, output register
    tab_dp #(
        .EDGE_SLOTS (EDGE_SLOTS),
        .INDEX_BITS (INDEX_BITS)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_action        (s_action),
        .s_vertex_a      (s_vertex_a),
        .s_vertex_b      (s_vertex_b),
        .s_vertex_c      (s_vertex_c),
        .cmd             (cmd),
        .sts             (sts),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_out_first     (m_out_first),
        .m_adj_across_ab (m_adj_across_ab),
        .m_out_second    (m_out_second),
        .m_adj_across_bc (m_adj_across_bc),
        .m_out_third     (m_out_third),
        .m_adj_across_ca (m_adj_across_ca)
    );

endmodule

// ----- tb/tb_triangle_adjacency_builder.sv -----
// testbench for the triangle adjacency builder: random and directed triangles, scoreboard check
module tb_triangle_adjacency_builder;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS = 4096;
    localparam logic [1:0] ACT_NOP = 2'd3;

    // expected result of one triangle transfer
    typedef struct {
        logic        status;
        logic [15:0] first, adj_ab, second, adj_bc, third, adj_ca;
    } adj_result_t;

    // edge table mirror and queue of pending results
    class adjacency_scoreboard;
        bit [31:0]   keys[SLOTS];
        bit [15:0]   vals[SLOTS];
        bit          used[SLOTS];
        int          count;
        adj_result_t pending[$];
        int          errors;
        int          checked;

        function int home(bit [31:0] key);
            bit [63:0] h;
            h = {32'd0, key} * tab_pkg::HASH_MULT;
            return h[63:32] % SLOTS;
        endfunction

        // returns found; slot gets the match, first empty, or SLOTS
        function bit probe(bit [31:0] key, output int slot);
            int s;
            s = home(key);
            for (int n = 0; n < SLOTS; n++) begin
                if (!used[s]) begin
                    slot = s;
                    return 0;
                end
                if (keys[s] == key) begin
                    slot = s;
                    return 1;
                end
                s = (s + 1) % SLOTS;
            end
            slot = SLOTS;
            return 0;
        endfunction

        function void put(bit [31:0] key, bit [15:0] v);
            int s;
            bit hit;
            hit = probe(key, s);
            if (s >= SLOTS) return;
            if (!hit) begin
                used[s] = 1;
                keys[s] = key;
                count++;
            end
            vals[s] = v;
        endfunction

        function bit [15:0] across(bit [15:0] from, bit [15:0] to, bit [15:0] dflt);
            int s;
            if (probe({from, to}, s)) return vals[s];
            return dflt;
        endfunction

        function void note_triangle(logic [1:0] act, logic [15:0] a, b, c);
            adj_result_t r;
            bit [31:0] k[3];
            bit [15:0] v[3];
            int fresh, s;
            bit dup;
            r = '{0, 0, 0, 0, 0, 0, 0};
            if (act == tab_pkg::ACT_INSERT) begin
                k[0] = {a, b}; v[0] = c;
                k[1] = {b, c}; v[1] = a;
                k[2] = {c, a}; v[2] = b;
                fresh = 0;
                for (int i = 0; i < 3; i++) begin
                    dup = 0;
                    for (int j = 0; j < i; j++) if (k[j] == k[i]) dup = 1;
                    if (!dup && !probe(k[i], s)) fresh++;
                end
                if (count + fresh > SLOTS) r.status = 1;
                else for (int i = 0; i < 3; i++) put(k[i], v[i]);
            end else if (act == tab_pkg::ACT_QUERY) begin
                r.first = a;  r.adj_ab = across(b, a, a);
                r.second = b; r.adj_bc = across(c, b, b);
                r.third = c;  r.adj_ca = across(a, c, c);
            end else if (act == tab_pkg::ACT_CLEAR) begin
                for (int i = 0; i < SLOTS; i++) used[i] = 0;
                count = 0;
            end
            pending.push_back(r);
        endfunction

        function void check_result(adj_result_t got);
            adj_result_t e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result transfer", $realtime);
                errors++;
                return;
            end
            e = pending.pop_front();
            checked++;
            if (got.status !== e.status) report("status", e.status, got.status);
            if (got.first !== e.first) report("out_first", e.first, got.first);
            if (got.adj_ab !== e.adj_ab) report("adj_across_ab", e.adj_ab, got.adj_ab);
            if (got.second !== e.second) report("out_second", e.second, got.second);
            if (got.adj_bc !== e.adj_bc) report("adj_across_bc", e.adj_bc, got.adj_bc);
            if (got.third !== e.third) report("out_third", e.third, got.third);
            if (got.adj_ca !== e.adj_ca) report("adj_across_ca", e.adj_ca, got.adj_ca);
        endfunction

        function void report(string field, logic [15:0] exp_v, logic [15:0] act_v);
            $display("%0t: %s mismatch, expected %0h actual %0h", $realtime, field, exp_v,
                act_v);
            errors++;
        endfunction
    endclass

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_valid = 0;
    logic        s_ready;
    logic [1:0]  s_action = ACT_NOP;
    logic [15:0] s_vertex_a = 0, s_vertex_b = 0, s_vertex_c = 0;
    logic        m_valid;
    logic        m_ready = 0;
    logic        m_status;
    logic [15:0] m_out_first, m_adj_across_ab, m_out_second, m_adj_across_bc;
    logic [15:0] m_out_third, m_adj_across_ca;

    triangle_adjacency_builder dut (.*);

    adjacency_scoreboard board = new();
    int send_idle_pct;   // chance per cycle that the sender holds off
    int recv_idle_pct;   // chance per cycle that the receiver stalls
    int sent;
    logic [15:0] pool[8];  // small vertex pool so triangles share edges

    initial forever #5 aclk = ~aclk;

    // result side: random stall, check every transfer
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            board.check_result('{m_status, m_out_first, m_adj_across_ab, m_out_second,
                m_adj_across_bc, m_out_third, m_adj_across_ca});
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // one triangle transfer, with random hold-off before raising valid
    task automatic send_triangle(logic [1:0] act, logic [15:0] a, b, c);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 0;
            @(posedge aclk);
        end
        s_valid <= 1;
        s_action <= act;
        s_vertex_a <= a;
        s_vertex_b <= b;
        s_vertex_c <= c;
        do @(posedge aclk); while (!s_ready);
        board.note_triangle(act, a, b, c);
        sent++;
    endtask

    function automatic logic [15:0] pick_vertex();
        case ($urandom_range(9))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2, 3: return 16'($urandom);
            default: return pool[$urandom_range(7)];
        endcase
    endfunction

    // random mix of inserts, queries, clears and idle actions, mostly over a small vertex pool
    task automatic random_phase(int n);
        logic [15:0] a, b, c;
        int r;
        for (int i = 0; i < n; i++) begin
            a = pick_vertex(); b = pick_vertex(); c = pick_vertex();
            r = $urandom_range(99);
            if (r < 50) send_triangle(tab_pkg::ACT_INSERT, a, b, c);
            else if (r < 90) send_triangle(tab_pkg::ACT_QUERY, a, b, c);
            else if (r < 93) send_triangle(tab_pkg::ACT_CLEAR, a, b, c);
            else if (r < 97) send_triangle(ACT_NOP, a, b, c);
            else send_triangle(tab_pkg::ACT_QUERY, b, a, c);
            if (i % 40 == 39)
                for (int k = 0; k < 8; k++) pool[k] = 16'($urandom);
        end
    endtask

    // bulk fill until the table runs out of room, then probe and clear
    task automatic fill_table();
        for (int i = 0; i < 2000 && board.count <= SLOTS - 3; i++)
            send_triangle(tab_pkg::ACT_INSERT, 16'(3 * i), 16'(3 * i + 1), 16'(3 * i + 2));
        send_triangle(tab_pkg::ACT_INSERT, 16'hFFFF, 16'hFFFE, 16'hFFFD);
        send_triangle(tab_pkg::ACT_INSERT, 16'd0, 16'd1, 16'd2);
        send_triangle(tab_pkg::ACT_QUERY, 16'd1, 16'd0, 16'd9);
        send_triangle(tab_pkg::ACT_QUERY, 16'd4101, 16'd4100, 16'd4102);
        send_triangle(tab_pkg::ACT_CLEAR, 16'd0, 16'd0, 16'd0);
        send_triangle(tab_pkg::ACT_QUERY, 16'd1, 16'd0, 16'd9);
    endtask

    initial begin
        send_idle_pct = 23;
        recv_idle_pct = 66;
        for (int k = 0; k < 8; k++) pool[k] = 16'($urandom);
        repeat (10) @(posedge aclk);
        aresetn <= 1;

        // directed: extremes, every action, degenerate and repeated edges
        send_triangle(tab_pkg::ACT_QUERY, 16'h0000, 16'hFFFF, 16'h1234);
        send_triangle(tab_pkg::ACT_INSERT, 16'h0000, 16'hFFFF, 16'h1234);
        send_triangle(tab_pkg::ACT_QUERY, 16'hFFFF, 16'h0000, 16'h5555);
        send_triangle(tab_pkg::ACT_QUERY, 16'h1234, 16'hFFFF, 16'h0000);
        send_triangle(tab_pkg::ACT_INSERT, 16'hFFFF, 16'h0000, 16'hAAAA);
        send_triangle(tab_pkg::ACT_QUERY, 16'h0000, 16'hFFFF, 16'h1234);
        send_triangle(tab_pkg::ACT_INSERT, 16'h0000, 16'hFFFF, 16'h7777);  // overwrite
        send_triangle(tab_pkg::ACT_QUERY, 16'hFFFF, 16'h0000, 16'h1234);
        send_triangle(tab_pkg::ACT_INSERT, 16'h0042, 16'h0042, 16'h0042);  // all edges equal
        send_triangle(tab_pkg::ACT_QUERY, 16'h0042, 16'h0042, 16'h0042);
        send_triangle(tab_pkg::ACT_INSERT, 16'h0010, 16'h0010, 16'h0020);  // two equal vertices
        send_triangle(tab_pkg::ACT_QUERY, 16'h0010, 16'h0020, 16'h0010);
        send_triangle(ACT_NOP, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_triangle(tab_pkg::ACT_CLEAR, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_triangle(tab_pkg::ACT_QUERY, 16'h0000, 16'hFFFF, 16'h1234);

        random_phase(40);
        fill_table();
        send_idle_pct = 66;
        recv_idle_pct = 23;
        random_phase(30);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_phase(30);
        s_valid <= 0;

        while (board.pending.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        $display("sent %0d triangles (insert, query, clear, idle action, full table)", sent);
        $display("checked %0d results, %0d mismatches", board.checked, board.errors);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // bound: every item probing the whole table six times under heavy stalls
    initial begin
        #3000ms;
        $display("timeout");
        $display("*** FAILED ***");
        $finish;
    end
endmodule
